[src/assert_macros.svh]
// assertion macros for the gradient map rtl, included by the divider
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define LGM_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
	else $error("lgm assertion failed");
// consequent checked in the cycle after the antecedent
`define LGM_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("lgm assertion failed");
`else
`define LGM_ASSERT(lbl, ck, rstn, prop)
`define LGM_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

[src/lgm_pkg.sv]
// shared constants and types of the gradient map core
package lgm_pkg;

	// q0.16 fixed point
	localparam int          Q_FRAC_BITS = 16;
	localparam logic [16:0] ONE_Q16     = 17'h10000;
	localparam logic [15:0] HALF_Q16    = 16'h8000;

	// quotient bits resolved per divider stage, must divide Q_FRAC_BITS
	localparam int DIV_STEPS_PER_STAGE = 2;
	// mod 2^c-1 folding steps per gray stage (two stages)
	localparam int FOLD_STEPS_PER_STAGE = 2;

	// register file
	localparam int REG_IDX_BITS = 3;
	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_COLOR_LO          = 3'd0,
		REG_COLOR_HI          = 3'd1,
		REG_SPLIT_POINT       = 3'd2,
		REG_OPACITY           = 3'd3,
		REG_GRAY_WEIGHT_RED   = 3'd4,
		REG_GRAY_WEIGHT_GREEN = 3'd5,
		REG_GRAY_WEIGHT_BLUE  = 3'd6
	} reg_idx_t;

	// reset values
	localparam logic [16:0] RST_OPACITY      = 17'h10000;
	localparam logic [15:0] RST_SPLIT_POINT  = 16'd0;
	localparam logic [15:0] RST_WEIGHT_RED   = 16'd19595;
	localparam logic [15:0] RST_WEIGHT_GREEN = 16'd38470;
	localparam logic [15:0] RST_WEIGHT_BLUE  = 16'd7471;

endpackage

[src/lgm_regs.sv]
// apb register file of the gradient map core with derived settings
module lgm_regs import lgm_pkg::*; #(
	parameter int CW = 8,
	parameter int DW = 32,
	parameter int AW = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [AW-1:0]   paddr,
	input  logic [DW-1:0]   pwdata,
	output logic [DW-1:0]   prdata,
	output logic            pready,
	output logic [3*CW-1:0] color_lo,
	output logic [3*CW-1:0] color_hi,
	output logic [15:0]     split_eff,
	output logic [16:0]     op_eff,
	output logic [16:0]     inv_op,
	output logic [15:0]     weight_red,
	output logic [15:0]     weight_green,
	output logic [15:0]     weight_blue
);

	logic [3*CW-1:0] color_lo_q;
	logic [3*CW-1:0] color_hi_q;
	logic [15:0]     split_point_q;
	logic [16:0]     opacity_q;
	logic [15:0]     weight_red_q;
	logic [15:0]     weight_green_q;
	logic [15:0]     weight_blue_q;
	reg_idx_t        idx;
	logic            wr_en;

	assign idx    = reg_idx_t'(paddr[AW-1:AW-REG_IDX_BITS]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_lo_q     <= '0;
			color_hi_q     <= '1;
			split_point_q  <= RST_SPLIT_POINT;
			opacity_q      <= RST_OPACITY;
			weight_red_q   <= RST_WEIGHT_RED;
			weight_green_q <= RST_WEIGHT_GREEN;
			weight_blue_q  <= RST_WEIGHT_BLUE;
		end else if (wr_en) begin
			case (idx)
				REG_COLOR_LO:          color_lo_q     <= pwdata[3*CW-1:0];
				REG_COLOR_HI:          color_hi_q     <= pwdata[3*CW-1:0];
				REG_SPLIT_POINT:       split_point_q  <= pwdata[15:0];
				REG_OPACITY:           opacity_q      <= pwdata[16:0];
				REG_GRAY_WEIGHT_RED:   weight_red_q   <= pwdata[15:0];
				REG_GRAY_WEIGHT_GREEN: weight_green_q <= pwdata[15:0];
				REG_GRAY_WEIGHT_BLUE:  weight_blue_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_COLOR_LO:          prdata = DW'(color_lo_q);
			REG_COLOR_HI:          prdata = DW'(color_hi_q);
			REG_SPLIT_POINT:       prdata = DW'(split_point_q);
			REG_OPACITY:           prdata = DW'(opacity_q);
			REG_GRAY_WEIGHT_RED:   prdata = DW'(weight_red_q);
			REG_GRAY_WEIGHT_GREEN: prdata = DW'(weight_green_q);
			REG_GRAY_WEIGHT_BLUE:  prdata = DW'(weight_blue_q);
			default:               prdata = '0;
		endcase
	end

	// zero split means one half, opacity saturates at one
	assign split_eff    = (split_point_q == 16'd0) ? HALF_Q16 : split_point_q;
	assign op_eff       = (opacity_q > ONE_Q16) ? ONE_Q16 : opacity_q;
	assign inv_op       = ONE_Q16 - op_eff;
	assign color_lo     = color_lo_q;
	assign color_hi     = color_hi_q;
	assign weight_red   = weight_red_q;
	assign weight_green = weight_green_q;
	assign weight_blue  = weight_blue_q;

endmodule

[src/lgm_gray.sv]
// gray level pipeline: weighted sum and exact division by the channel maximum
module lgm_gray import lgm_pkg::*; #(
	parameter int CW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  logic [3*CW-1:0] up_src,
	input  logic [15:0]     weight_red,
	input  logic [15:0]     weight_green,
	input  logic [15:0]     weight_blue,
	output logic            dn_valid,
	input  logic            dn_ready,
	output logic [16:0]     dn_gray,
	output logic [3*CW-1:0] dn_src
);

	localparam int PW = CW + 16;
	localparam int SW = CW + 18;
	localparam logic [SW-1:0] MASK    = {{(SW-CW){1'b0}}, {CW{1'b1}}};
	localparam logic [SW-1:0] SAT_LIM = {2'b00, {CW{1'b1}}, 16'h0000};

	logic            v_s1, v_s2, v_s3, v_s4;
	logic            en_s1, en_s2, en_s3, en_s4;
	logic [PW-1:0]   pr_s1, pg_s1, pb_s1;
	logic [3*CW-1:0] src_s1, src_s2, src_s3, src_s4;
	logic [SW-1:0]   sum_s2;
	logic            sat_s2, sat_s3;
	logic [SW-1:0]   r_s3, q_s3;
	logic [16:0]     gray_s4;
	logic [SW-1:0]   sum_c;
	logic [SW-1:0]   r3_c, q3_c, r4_c, q4_c;

	// stage enables, a stage moves when empty or when its successor moves
	assign en_s4    = !v_s4 || dn_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign up_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= up_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// weighted sum and saturation test
	assign sum_c = SW'(pr_s1) + SW'(pg_s1) + SW'(pb_s1);

	// first folding steps, sum = q*(2^c-1) + r is kept throughout
	always_comb begin
		logic [SW-1:0] t;
		r3_c = sum_s2;
		q3_c = '0;
		for (int j = 0; j < FOLD_STEPS_PER_STAGE; j++) begin
			t    = r3_c >> CW;
			q3_c = q3_c + t;
			r3_c = (r3_c & MASK) + t;
		end
	end

	// last folding steps and final correction
	always_comb begin
		logic [SW-1:0] t;
		r4_c = r_s3;
		q4_c = q_s3;
		for (int j = 0; j < FOLD_STEPS_PER_STAGE; j++) begin
			t    = r4_c >> CW;
			q4_c = q4_c + t;
			r4_c = (r4_c & MASK) + t;
		end
		if (r4_c == MASK) begin
			q4_c = q4_c + SW'(1);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en_s1) begin
			pr_s1  <= PW'(weight_red)   * PW'(up_src[2*CW +: CW]);
			pg_s1  <= PW'(weight_green) * PW'(up_src[CW +: CW]);
			pb_s1  <= PW'(weight_blue)  * PW'(up_src[0 +: CW]);
			src_s1 <= up_src;
		end
		if (en_s2) begin
			sum_s2 <= sum_c;
			sat_s2 <= (sum_c >= SAT_LIM);
			src_s2 <= src_s1;
		end
		if (en_s3) begin
			r_s3   <= r3_c;
			q_s3   <= q3_c;
			sat_s3 <= sat_s2;
			src_s3 <= src_s2;
		end
		if (en_s4) begin
			gray_s4 <= sat_s3 ? ONE_Q16 : {1'b0, q4_c[15:0]};
			src_s4  <= src_s3;
		end
	end

	assign dn_valid = v_s4;
	assign dn_gray  = gray_s4;
	assign dn_src   = src_s4;

endmodule

[src/lgm_div.sv]
// pipelined restoring divider for the ramp position within a segment
`include "assert_macros.svh"
module lgm_div import lgm_pkg::*; #(
	parameter int SIDE_W = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  logic [16:0]       up_gray,
	input  logic [SIDE_W-1:0] up_side,
	input  logic [15:0]       split_eff,
	output logic              dn_valid,
	input  logic              dn_ready,
	output logic [16:0]       dn_k,
	output logic              dn_lower,
	output logic [SIDE_W-1:0] dn_side
);

	localparam int NSTG = 1 + Q_FRAC_BITS / DIV_STEPS_PER_STAGE;
	localparam int LAST = NSTG - 1;

	logic              vld_s  [NSTG];
	logic              en_s   [NSTG];
	logic [15:0]       rem_s  [NSTG];
	logic [16:0]       quo_s  [NSTG];
	logic [15:0]       den_s  [NSTG];
	logic              low_s  [NSTG];
	logic [SIDE_W-1:0] side_s [NSTG];

	logic        lower_c;
	logic [15:0] num_c, den_c;
	logic        q16_c;

	// enable chain from the output back to the entry
	always_comb begin
		en_s[LAST] = !vld_s[LAST] || dn_ready;
		for (int i = LAST - 1; i >= 0; i--) begin
			en_s[i] = !vld_s[i] || en_s[i+1];
		end
	end
	assign up_ready = en_s[0];

	// segment select: numerator never exceeds the divisor
	always_comb begin
		lower_c = (up_gray < {1'b0, split_eff});
		num_c   = lower_c ? up_gray[15:0] : 16'(up_gray - {1'b0, split_eff});
		den_c   = lower_c ? split_eff : 16'(ONE_Q16 - {1'b0, split_eff});
		q16_c   = !lower_c && (num_c == den_c);
	end

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en_s[0]) begin
			vld_s[0] <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s[0]) begin
			rem_s[0]  <= q16_c ? 16'd0 : num_c;
			quo_s[0]  <= {16'd0, q16_c};
			den_s[0]  <= den_c;
			low_s[0]  <= lower_c;
			side_s[0] <= up_side;
		end
	end

	// iteration stages, a few quotient bits each
	for (genvar i = 1; i < NSTG; i++) begin : g_stage
		logic [15:0] r_nx;
		logic [16:0] q_nx;

		always_comb begin
			logic [16:0] t;
			r_nx = rem_s[i-1];
			q_nx = quo_s[i-1];
			for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
				t = {r_nx, 1'b0};
				if (t >= {1'b0, den_s[i-1]}) begin
					r_nx = 16'(t - {1'b0, den_s[i-1]});
					q_nx = {q_nx[15:0], 1'b1};
				end else begin
					r_nx = t[15:0];
					q_nx = {q_nx[15:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en_s[i]) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_s[i]) begin
				rem_s[i]  <= r_nx;
				quo_s[i]  <= q_nx;
				den_s[i]  <= den_s[i-1];
				low_s[i]  <= low_s[i-1];
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign dn_valid = vld_s[LAST];
	assign dn_k     = quo_s[LAST];
	assign dn_lower = low_s[LAST];
	assign dn_side  = side_s[LAST];

	// remainder stays below the divisor
	`LGM_ASSERT(a_rem_below_den, clk, arst_n, vld_s[LAST] |-> (rem_s[LAST] < den_s[LAST]))
	// lower segment position is always below one
	`LGM_ASSERT(a_lower_below_one, clk, arst_n, (vld_s[LAST] && low_s[LAST]) |-> !quo_s[LAST][16])
	// a position of one has no fraction bits
	`LGM_ASSERT(a_one_exact, clk, arst_n, (vld_s[LAST] && quo_s[LAST][16]) |-> (quo_s[LAST][15:0] == 16'd0))
	// a stalled result is held at the divider output
	`LGM_ASSERT_NEXT(a_hold_stalled, clk, arst_n, vld_s[LAST] && !dn_ready, vld_s[LAST] && $stable(quo_s[LAST]))

endmodule

[src/lgm_blend.sv]
// ramp colour and opacity blend per channel, ends in the output register
module lgm_blend import lgm_pkg::*; #(
	parameter int CW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  logic [16:0]     up_k,
	input  logic            up_lower,
	input  logic [3*CW-1:0] up_src,
	input  logic [3*CW-1:0] color_lo,
	input  logic [3*CW-1:0] color_hi,
	input  logic [16:0]     op_eff,
	input  logic [16:0]     inv_op,
	output logic            dn_valid,
	input  logic            dn_ready,
	output logic [3*CW-1:0] dn_pix
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	logic low_s1;
	logic signed [17:0] kx;

	assign en_s4    = !v_s4 || dn_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign up_ready = en_s1;
	assign kx       = signed'({1'b0, up_k});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= up_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			low_s1 <= up_lower;
		end
	end

	// one lane per channel: red, green, blue from the top
	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic [CW-1:0]      s, e;
		logic [CW:0]        se;
		logic signed [CW:0] diff;
		logic [CW+18:0]     base_u;
		logic signed [CW+18:0] g;
		logic [CW+33:0]     total;

		logic signed [CW+18:0] prod_s1;
		logic [CW-1:0]      src_s1, src_s2;
		logic [CW+16:0]     g_s2;
		logic [CW+33:0]     mg_s3;
		logic [CW+16:0]     ms_s3;
		logic [CW-1:0]      out_s4;

		assign s    = color_lo[(2-c)*CW +: CW];
		assign e    = color_hi[(2-c)*CW +: CW];
		assign se   = {1'b0, s} + {1'b0, e};
		assign diff = signed'({1'b0, e}) - signed'({1'b0, s});

		// ramp base: start stop or centre stop, in 2^-17 units
		assign base_u = low_s1 ? {2'b00, s, 17'd0} : {2'b00, se, 16'd0};
		assign g      = signed'(base_u) + prod_s1;

		// blended sum, shifted down by 33 bits
		assign total = mg_s3 + {ms_s3, 17'd0};

		always_ff @(posedge clk) begin
			if (en_s1) begin
				prod_s1 <= (CW+19)'(diff) * (CW+19)'(kx);
				src_s1  <= up_src[(2-c)*CW +: CW];
			end
			if (en_s2) begin
				g_s2   <= g[CW+18] ? '0 : g[CW+16:0];
				src_s2 <= src_s1;
			end
			if (en_s3) begin
				mg_s3 <= (CW+34)'(g_s2) * (CW+34)'(op_eff);
				ms_s3 <= (CW+17)'(src_s2) * (CW+17)'(inv_op);
			end
			if (en_s4) begin
				out_s4 <= total[CW+33] ? '1 : total[CW+32:33];
			end
		end

		assign dn_pix[(2-c)*CW +: CW] = out_s4;
	end

	assign dn_valid = v_s4;

endmodule

[src/luminance_gradient_map_core.sv]
// top level of the three-stop gradient map core
//
// Pixel stream in, mapped pixel stream out. Input beats carry in_red,
// in_green and in_blue and are taken at a clock edge with in_valid high
// and in_stall low; output beats carry out_red, out_green and out_blue
// and are handed over when out_valid is high and out_stall is low.
// Throughput is one pixel per clock while out_stall is low. A beat taken
// passes four stages that form the gray level, nine that run the position
// divider (a segment select stage, then two quotient bits per stage) and
// four that build the ramp colour and the blend, the last one being the
// output register.
// When out_stall is held, finished pixels wait in the output register and
// empty stages behind it keep filling; in_stall rises only once every
// stage holds a pixel. Nothing is dropped or repeated.
// Settings are written through the apb port; the user is bound to write
// them only while the stream is idle, which the block leaves unchecked.
// pready is always high. Reset clears the pipeline and loads the default
// registers: black to white ramp, centre at one half, fully opaque, and the usual luma weights.
module luminance_gradient_map_core import lgm_pkg::*; #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CHANNEL_BITS-1:0] in_red,
	input  logic [CHANNEL_BITS-1:0] in_green,
	input  logic [CHANNEL_BITS-1:0] in_blue,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CHANNEL_BITS-1:0] out_red,
	output logic [CHANNEL_BITS-1:0] out_green,
	output logic [CHANNEL_BITS-1:0] out_blue,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [REG_IDX_BITS + ((3*CHANNEL_BITS > 32) ? 3 : 2) - 1:0] paddr,
	input  logic [((3*CHANNEL_BITS > 32) ? 64 : 32) - 1:0]              pwdata,
	output logic [((3*CHANNEL_BITS > 32) ? 64 : 32) - 1:0]              prdata,
	output logic                    pready
);

	localparam int CW = CHANNEL_BITS;
	localparam int DW = (3*CW > 32) ? 64 : 32;
	localparam int AW = REG_IDX_BITS + ((3*CW > 32) ? 3 : 2);

	logic [3*CW-1:0] color_lo, color_hi;
	logic [15:0]     split_eff;
	logic [16:0]     op_eff, inv_op;
	logic [15:0]     weight_red, weight_green, weight_blue;

	logic            gray_ready, gray_valid;
	logic [16:0]     gray;
	logic [3*CW-1:0] gray_src;
	logic            div_ready, div_valid;
	logic [16:0]     div_k;
	logic            div_lower;
	logic [3*CW-1:0] div_src;
	logic            blend_ready;
	logic [3*CW-1:0] out_pix;

	// configuration registers
	lgm_regs #(.CW(CW), .DW(DW), .AW(AW)) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.color_lo     (color_lo),
		.color_hi     (color_hi),
		.split_eff    (split_eff),
		.op_eff       (op_eff),
		.inv_op       (inv_op),
		.weight_red   (weight_red),
		.weight_green (weight_green),
		.weight_blue  (weight_blue)
	);

	// gray level
	lgm_gray #(.CW(CW)) u_gray (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (in_valid),
		.up_ready     (gray_ready),
		.up_src       ({in_red, in_green, in_blue}),
		.weight_red   (weight_red),
		.weight_green (weight_green),
		.weight_blue  (weight_blue),
		.dn_valid     (gray_valid),
		.dn_ready     (div_ready),
		.dn_gray      (gray),
		.dn_src       (gray_src)
	);

	// position within the ramp segment
	lgm_div #(.SIDE_W(3*CW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (gray_valid),
		.up_ready  (div_ready),
		.up_gray   (gray),
		.up_side   (gray_src),
		.split_eff (split_eff),
		.dn_valid  (div_valid),
		.dn_ready  (blend_ready),
		.dn_k      (div_k),
		.dn_lower  (div_lower),
		.dn_side   (div_src)
	);

	// ramp colour, blend and output register
	lgm_blend #(.CW(CW)) u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (div_valid),
		.up_ready    (blend_ready),
		.up_k        (div_k),
		.up_lower    (div_lower),
		.up_src      (div_src),
		.color_lo    (color_lo),
		.color_hi    (color_hi),
		.op_eff      (op_eff),
		.inv_op      (inv_op),
		.dn_valid    (out_valid),
		.dn_ready    (!out_stall),
		.dn_pix      (out_pix)
	);

	assign in_stall  = !gray_ready;
	assign out_red   = out_pix[2*CW +: CW];
	assign out_green = out_pix[CW +: CW];
	assign out_blue  = out_pix[0 +: CW];

endmodule

[dv/luminance_gradient_map_core_tb.sv]
// self-checking testbench of the three-stop gradient map core
module luminance_gradient_map_core_tb import lgm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CH_BITS     = 8;
	localparam longint CH_MAX      = (64'd1 << CH_BITS) - 1;
	localparam longint Q_ONE       = longint'(ONE_Q16);
	localparam longint Q_HALF      = longint'(HALF_Q16);
	localparam int     CYCLE_LIMIT = 200000;
	localparam int     HOLD_CYCLES = 120;
	// address one past the register list, writes there must be ignored
	localparam logic [REG_IDX_BITS-1:0] UNUSED_REG_IDX = 3'd7;

	typedef struct packed {
		logic [CH_BITS-1:0] red;
		logic [CH_BITS-1:0] green;
		logic [CH_BITS-1:0] blue;
	} pixel_t;

	typedef enum logic [1:0] {
		STALL_NEVER,
		STALL_RANDOM,
		STALL_PATTERN
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CH_BITS-1:0] in_red = '0;
	logic [CH_BITS-1:0] in_green = '0;
	logic [CH_BITS-1:0] in_blue = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CH_BITS-1:0] out_red;
	logic [CH_BITS-1:0] out_green;
	logic [CH_BITS-1:0] out_blue;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [REG_IDX_BITS+1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// register shadow used by the pixel predictor
	logic [3*CH_BITS-1:0] cfg_color_lo = '0;
	logic [3*CH_BITS-1:0] cfg_color_hi = '1;
	logic [15:0] cfg_split_point = RST_SPLIT_POINT;
	logic [16:0] cfg_opacity = RST_OPACITY;
	logic [15:0] cfg_weight_red = RST_WEIGHT_RED;
	logic [15:0] cfg_weight_green = RST_WEIGHT_GREEN;
	logic [15:0] cfg_weight_blue = RST_WEIGHT_BLUE;

	pixel_t pixel_q[$];
	pixel_t mapped_q[$];
	pixel_t next_beat;
	pixel_t want;
	logic pixel_taken = 1'b0;
	int gap_left = 0;
	int burst_left = 0;
	bit bursty = 1'b0;
	stall_mode_t stall_mode = STALL_NEVER;
	logic [7:0] stall_pattern = '0;
	logic [2:0] stall_phase = '0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	bit hold_on = 1'b0;
	int hold_left = 0;
	int error_count = 0;
	int cycle_count = 0;

	luminance_gradient_map_core #(.CHANNEL_BITS(CH_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_red(in_red),
		.in_green(in_green),
		.in_blue(in_blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// gray level, ramp position, ramp colour and opacity blend of one pixel
	function automatic pixel_t map_pixel(input pixel_t src);
		longint luma, split, op, pos, ramp, blend, s_ch, e_ch, src_ch;
		logic [CH_BITS-1:0] src_arr [3];
		logic [CH_BITS-1:0] res_arr [3];
		bit lower;
		pixel_t res;
		src_arr[0] = src.red;
		src_arr[1] = src.green;
		src_arr[2] = src.blue;
		luma = (longint'(cfg_weight_red) * longint'(src.red) +
			longint'(cfg_weight_green) * longint'(src.green) +
			longint'(cfg_weight_blue) * longint'(src.blue)) / CH_MAX;
		if (luma > Q_ONE)
			luma = Q_ONE;
		split = (cfg_split_point == 0) ? Q_HALF : longint'(cfg_split_point);
		op = (longint'(cfg_opacity) > Q_ONE) ? Q_ONE : longint'(cfg_opacity);
		lower = luma < split;
		if (lower)
			pos = (luma << 16) / split;
		else
			pos = ((luma - split) << 16) / (Q_ONE - split);
		for (int c = 0; c < 3; c++) begin
			s_ch = longint'(cfg_color_lo[CH_BITS*(2-c) +: CH_BITS]);
			e_ch = longint'(cfg_color_hi[CH_BITS*(2-c) +: CH_BITS]);
			src_ch = longint'(src_arr[c]);
			// ramp colour in units of 2^-17
			if (lower)
				ramp = s_ch * 131072 + (e_ch - s_ch) * pos;
			else
				ramp = (s_ch + e_ch) * 65536 + (e_ch - s_ch) * pos;
			if (ramp < 0)
				ramp = 0;
			blend = (ramp * op + (src_ch << 17) * (Q_ONE - op)) >>> 33;
			if (blend > CH_MAX)
				blend = CH_MAX;
			res_arr[c] = blend[CH_BITS-1:0];
		end
		res.red = res_arr[0];
		res.green = res_arr[1];
		res.blue = res_arr[2];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < 40)
			$display("%0t mismatch: %s", $time, msg);
		error_count++;
	endtask

	// register write over apb, shadow updated alongside
	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
		case (idx)
			REG_COLOR_LO:          cfg_color_lo = value[3*CH_BITS-1:0];
			REG_COLOR_HI:          cfg_color_hi = value[3*CH_BITS-1:0];
			REG_SPLIT_POINT:       cfg_split_point = value[15:0];
			REG_OPACITY:           cfg_opacity = value[16:0];
			REG_GRAY_WEIGHT_RED:   cfg_weight_red = value[15:0];
			REG_GRAY_WEIGHT_GREEN: cfg_weight_green = value[15:0];
			REG_GRAY_WEIGHT_BLUE:  cfg_weight_blue = value[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic push_pixel(input int r, input int g, input int b);
		pixel_t p;
		p.red = r[CH_BITS-1:0];
		p.green = g[CH_BITS-1:0];
		p.blue = b[CH_BITS-1:0];
		pixel_q.push_back(p);
	endtask

	// random pixels, channel extremes mixed in
	task automatic push_random(input int count);
		int ch [3];
		repeat (count) begin
			for (int c = 0; c < 3; c++) begin
				case ($urandom_range(0, 7))
					0: ch[c] = 0;
					1: ch[c] = int'(CH_MAX);
					default: ch[c] = $urandom_range(0, int'(CH_MAX));
				endcase
			end
			push_pixel(ch[0], ch[1], ch[2]);
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pixel_q.size() != 0 || in_valid || mapped_q.size() != 0);
	endtask

	// random settings for one phase, extremes drawn now and then
	task automatic random_config();
		logic [31:0] wr, wg, wb, op;
		case ($urandom_range(0, 3))
			0: write_reg(REG_COLOR_LO, 32'h0);
			1: write_reg(REG_COLOR_LO, 32'hFFFFFF);
			default: write_reg(REG_COLOR_LO, $urandom);
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(REG_COLOR_HI, 32'h0);
			1: write_reg(REG_COLOR_HI, 32'hFFFFFF);
			default: write_reg(REG_COLOR_HI, $urandom);
		endcase
		case ($urandom_range(0, 5))
			0: write_reg(REG_SPLIT_POINT, 32'd0);
			1: write_reg(REG_SPLIT_POINT, 32'd1);
			2: write_reg(REG_SPLIT_POINT, 32'd65535);
			default: write_reg(REG_SPLIT_POINT, $urandom_range(0, 65535));
		endcase
		case ($urandom_range(0, 5))
			0: op = 32'd0;
			1: op = 32'd65536;
			2: op = 32'h1FFFF;
			3: op = $urandom;
			default: op = $urandom_range(0, 65536);
		endcase
		write_reg(REG_OPACITY, op);
		// weights summing to at most one, or anything at all
		if ($urandom_range(0, 3) == 0) begin
			wr = $urandom;
			wg = $urandom;
			wb = $urandom;
		end else begin
			wr = $urandom_range(0, 40000);
			wg = $urandom_range(0, 65535 - wr);
			wb = $urandom_range(0, 65535 - wr - wg);
		end
		write_reg(REG_GRAY_WEIGHT_RED, wr);
		write_reg(REG_GRAY_WEIGHT_GREEN, wg);
		write_reg(REG_GRAY_WEIGHT_BLUE, wb);
	endtask

	// input driver: bursts of beats with random gaps between them
	always @(negedge clk) begin
		if (arst_n && (!in_valid || pixel_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pixel_q.size() != 0) begin
				next_beat = pixel_q.pop_front();
				in_red <= next_beat.red;
				in_green <= next_beat.green;
				in_blue <= next_beat.blue;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					if (!bursty)
						gap_left <= 0;
					else if ($urandom_range(0, 3) == 0)
						gap_left <= $urandom_range(1, 12);
					else
						gap_left <= $urandom_range(0, 2);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted in cycles once requested
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			if (!hold_on) begin
				hold_on <= 1'b1;
				hold_left <= HOLD_CYCLES;
			end else if (hold_left > 1) begin
				hold_left <= hold_left - 1;
			end else begin
				hold_on <= 1'b0;
				hold_done <= 1'b1;
			end
		end
	end

	// output stall pattern, plus the long hold-off
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1'b1;
		case (stall_mode)
			STALL_RANDOM:  out_stall <= hold_on || ($urandom_range(0, 3) == 0);
			STALL_PATTERN: out_stall <= hold_on || stall_pattern[stall_phase];
			default:       out_stall <= hold_on;
		endcase
	end

	// accepted input beats become expected pixels, output beats are checked
	always @(posedge clk) begin
		pixel_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			mapped_q.push_back(map_pixel({in_red, in_green, in_blue}));
		if (arst_n && out_valid && !out_stall) begin
			if (mapped_q.size() == 0) begin
				report_mismatch($sformatf("output beat %0d/%0d/%0d with none expected",
					out_red, out_green, out_blue));
			end else begin
				want = mapped_q.pop_front();
				if (out_red !== want.red)
					report_mismatch($sformatf("out_red %0d, want %0d", out_red, want.red));
				if (out_green !== want.green)
					report_mismatch($sformatf("out_green %0d, want %0d", out_green, want.green));
				if (out_blue !== want.blue)
					report_mismatch($sformatf("out_blue %0d, want %0d", out_blue, want.blue));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("luminance_gradient_map_core_tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: black to white, luma weights
		push_pixel(0, 0, 0);
		push_pixel(255, 255, 255);
		push_pixel(255, 0, 0);
		push_pixel(0, 255, 0);
		push_pixel(0, 0, 255);
		push_pixel(128, 128, 128);
		wait_drained();

		// red-only gray lands exactly on the split point at red 128
		write_reg(UNUSED_REG_IDX, 32'h1234);
		write_reg(REG_GRAY_WEIGHT_RED, 32'd65535);
		write_reg(REG_GRAY_WEIGHT_GREEN, 32'd0);
		write_reg(REG_GRAY_WEIGHT_BLUE, 32'd0);
		write_reg(REG_SPLIT_POINT, 32'd32896);
		push_pixel(127, 40, 200);
		push_pixel(128, 40, 200);
		push_pixel(129, 40, 200);
		push_pixel(255, 0, 0);
		push_pixel(0, 255, 255);
		wait_drained();

		// saturated gray and opacity, red ramp falling and blue rising, split at the top
		write_reg(REG_GRAY_WEIGHT_GREEN, 32'd65535);
		write_reg(REG_GRAY_WEIGHT_BLUE, 32'd65535);
		write_reg(REG_COLOR_LO, 32'hFFFF8000);
		write_reg(REG_COLOR_HI, 32'h000080FF);
		write_reg(REG_SPLIT_POINT, 32'd65535);
		write_reg(REG_OPACITY, 32'hFFFFFFFF);
		push_pixel(255, 255, 255);
		push_pixel(1, 1, 1);
		push_pixel(0, 0, 0);
		push_pixel(200, 10, 90);
		wait_drained();

		// fully transparent, split at the bottom
		write_reg(REG_OPACITY, 32'd0);
		write_reg(REG_SPLIT_POINT, 32'd1);
		push_pixel(255, 0, 128);
		push_pixel(0, 255, 7);
		push_pixel(12, 34, 56);
		wait_drained();

		// half opacity, zero split standing for one half
		write_reg(REG_OPACITY, 32'd32768);
		write_reg(REG_SPLIT_POINT, 32'd0);
		write_reg(REG_COLOR_LO, 32'h3C9A12);
		push_pixel(255, 255, 255);
		push_pixel(0, 0, 0);
		push_pixel(90, 160, 220);
		wait_drained();

		// back pressure: receiver holds off while the sender keeps going
		random_config();
		bursty = 1'b0;
		stall_mode = STALL_NEVER;
		@(posedge clk);
		hold_req = 1'b1;
		push_random(120);
		wait (hold_done);
		wait_drained();

		// random phases, the first one without idling on either side
		for (int ph = 0; ph < 8; ph++) begin
			random_config();
			if (ph == 0) begin
				bursty = 1'b0;
				stall_mode = STALL_NEVER;
			end else begin
				bursty = $urandom_range(0, 1);
				stall_mode = stall_mode_t'($urandom_range(0, 2));
				stall_pattern = 8'($urandom) & 8'h7F;
			end
			push_random(80);
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("luminance_gradient_map_core_tb: clean");
		else
			$display("luminance_gradient_map_core_tb: errors");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/lgm_pkg.sv
src/lgm_regs.sv
src/lgm_gray.sv
src/lgm_div.sv
src/lgm_blend.sv
src/luminance_gradient_map_core.sv
dv/luminance_gradient_map_core_tb.sv
